// File: hw/rtl/symbol_count_record_parser_unit_macros.svh
// assertion macros for the symbol count record parser
// expects clk and arst_n in the scope of the use
`ifndef SYMBOL_COUNT_RECORD_PARSER_UNIT_MACROS_SVH
`define SYMBOL_COUNT_RECORD_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define SCRP_ASSERT_NOW(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("scrp same-cycle check failed");

// next-cycle implication
`define SCRP_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("scrp next-cycle check failed");

`endif

// File: hw/rtl/scrp_pkg.sv
// shared types and constants for the symbol count record parser
// no dependencies
`default_nettype none

package scrp_pkg;

	localparam int SYM_W = 8;
	localparam int COUNT_W = 31;
	localparam int ERR_W = 2;
	localparam int PROD_W = COUNT_W + 4;

	localparam logic [SYM_W-1:0] BAR_CHAR = 8'd124;
	localparam logic [SYM_W-1:0] ZERO_CHAR = 8'd48;
	localparam logic [SYM_W-1:0] NINE_CHAR = 8'd57;

	localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
	localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
	localparam logic [ERR_W-1:0] ERR_BADCHAR = 2'd2;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd3;

	typedef struct packed {
		logic [SYM_W-1:0] held_symbol;
		logic [COUNT_W-1:0] count_acc;
		logic digit_seen;
		logic [ERR_W-1:0] failure_code;
	} parse_state_t;

	typedef struct packed {
		logic entry_valid;
		logic [SYM_W-1:0] entry_symbol;
		logic [COUNT_W-1:0] entry_count;
		logic [ERR_W-1:0] error_code;
	} entry_t;

	localparam parse_state_t STATE_RESET = '{
		held_symbol: BAR_CHAR,
		count_acc: '0,
		digit_seen: 1'b0,
		failure_code: ERR_NONE
	};

endpackage

`default_nettype wire

// File: hw/rtl/scrp_step.sv
// one parse step: next record state and result entry for one byte
// depends on scrp_pkg
`default_nettype none

module scrp_step
	import scrp_pkg::*;
(
	input  wire parse_state_t     cur,
	input  wire logic [SYM_W-1:0] text_byte,
	output parse_state_t          nxt,
	output entry_t                entry
);

	logic [PROD_W-1:0] acc_ext;
	logic [PROD_W-1:0] prod;

	// count * 10 + digit as two shifts and two adds
	assign acc_ext = {4'b0, cur.count_acc};
	assign prod = (acc_ext << 3) + (acc_ext << 1) + {{(PROD_W-4){1'b0}}, text_byte[3:0]};

	always_comb begin
		nxt = cur;
		entry.entry_valid = 1'b0;
		entry.entry_symbol = '0;
		entry.entry_count = '0;
		if (cur.failure_code == ERR_NONE) begin
			if (cur.held_symbol == BAR_CHAR) begin
				nxt.held_symbol = text_byte;
			end else if (text_byte == BAR_CHAR) begin
				if (!cur.digit_seen) begin
					nxt.failure_code = ERR_EMPTY;
				end else begin
					entry.entry_valid = 1'b1;
					entry.entry_symbol = cur.held_symbol;
					entry.entry_count = cur.count_acc;
					nxt.held_symbol = BAR_CHAR;
					nxt.count_acc = '0;
					nxt.digit_seen = 1'b0;
				end
			end else if (text_byte inside {[ZERO_CHAR:NINE_CHAR]}) begin
				if (prod[PROD_W-1:COUNT_W] != '0) begin
					nxt.failure_code = ERR_OVERFLOW;
				end else begin
					nxt.count_acc = prod[COUNT_W-1:0];
					nxt.digit_seen = 1'b1;
				end
			end else begin
				nxt.failure_code = ERR_BADCHAR;
			end
		end
		entry.error_code = nxt.failure_code;
	end

endmodule

`default_nettype wire

// File: hw/rtl/symbol_count_record_parser_unit.sv
// symbol count record parser: an accepted byte passes the input stage, then the output register, to entry valid
// throughput one byte per cycle while the output is not stalled; the multiply-by-ten and compare sit in one stage
// an input stage and an output register part the two sides, so a byte is taken
// while a finished entry waits
// reset clears the record state, the sticky error and both valid flags
// depends on scrp_pkg, scrp_step and the assertion macro header
`default_nettype none
`include "symbol_count_record_parser_unit_macros.svh"

module symbol_count_record_parser_unit
	import scrp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // text_byte[7:0]
	input  wire logic        s_tlast,  // last_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,  // entry_symbol[7:0], entry_count[38:8], zero[39]
	output logic [2:0]       m_tuser,  // entry_valid[0], error_code[2:1]
	output logic             m_tlast   // text_done
);

	logic             valid_s1;
	logic [SYM_W-1:0] byte_s1;
	logic             last_s1;
	logic             advance;
	parse_state_t     state_q;
	parse_state_t     state_nxt;
	entry_t           entry_nxt;
	entry_t           out_q;
	logic             done_q;
	logic             out_valid_q;

	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	scrp_step u_step (
		.cur       (state_q),
		.text_byte (byte_s1),
		.nxt       (state_nxt),
		.entry     (entry_nxt)
	);

	// record state, back to reset after the last item of a text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= last_s1 ? STATE_RESET : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= entry_nxt;
			done_q <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {1'b0, out_q.entry_count, out_q.entry_symbol};
	assign m_tuser = {out_q.error_code, out_q.entry_valid};
	assign m_tlast = done_q;

	`SCRP_ASSERT_NOW(a_entry_no_error, out_valid_q && out_q.entry_valid,
		out_q.error_code == ERR_NONE)
	`SCRP_ASSERT_NEXT(a_last_clears_state, advance && last_s1,
		state_q == STATE_RESET)
	`SCRP_ASSERT_NEXT(a_error_sticky, advance && !last_s1 && state_q.failure_code != ERR_NONE,
		$stable(state_q.failure_code))
	`SCRP_ASSERT_NEXT(a_out_holds_stalled, out_valid_q && !m_tready,
		out_valid_q && $stable(out_q))

endmodule

`default_nettype wire
